// File: src/aesd_pkg.sv
`default_nettype none
package aesd_pkg;

   localparam int KeyWords = 60;
   localparam int KeyAddrW = 6;

   localparam logic [2:0] CSR_KEY_SIZE = 3'd0;
   localparam logic [2:0] CSR_KEY_W0   = 3'd1;
   localparam logic [2:0] CSR_KEY_W1   = 3'd2;
   localparam logic [2:0] CSR_KEY_W2   = 3'd3;
   localparam logic [2:0] CSR_KEY_W3   = 3'd4;

   localparam logic [1:0] KEY_128 = 2'd0;
   localparam logic [1:0] KEY_192 = 2'd1;

   typedef enum logic [1:0] {
      DP_HOLD,
      DP_LOAD,
      DP_ROUND,
      DP_LAST
   } dp_op_type;

   // Controller to datapath commands.
   typedef struct packed {
      dp_op_type               op;        // state operation this cycle
      logic                    ks_seed;   // write raw key word
      logic                    ks_step;   // write expanded key word
      logic                    ks_rot;    // apply RotWord/SubWord/Rcon
      logic                    ks_sub;    // apply SubWord only
      logic                    rc_init;
      logic [2:0]              ks_seed_idx;
      logic [2:0]              ks_back;   // history slot holding word i-nk
      logic [KeyAddrW-1:0]     ks_waddr;
      logic [KeyAddrW-1:0]     rk_raddr;  // round key base word
      logic [1:0]              rk_col;    // column being read
      logic                    rk_col_we; // capture read column
   } aesd_cmd_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] inv_sbox(input logic [7:0] v);
      logic [7:0] r;
      r = 8'h00;
      for (int i = 0; i < 256; i++)
         if (SBOX[i] == v) r = 8'(i);
      return r;
   endfunction

   function automatic logic [7:0] xt(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

endpackage
`default_nettype wire

// File: src/aesd_ram.sv
`default_nettype none
module aesd_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(Depth)-1:0] waddr,
   input  wire logic [Width-1:0]         wdata,
   input  wire logic [$clog2(Depth)-1:0] raddr,
   output logic      [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// File: src/aesd_datapath.sv
`default_nettype none
module aesd_datapath (
   input  wire logic                   clock,
   input  wire aesd_pkg::aesd_cmd_type cmd,
   input  wire logic [255:0]           key,
   input  wire logic [63:0]            din_hi,
   input  wire logic [63:0]            din_lo,
   output logic      [127:0]           state_out
);
   logic [127:0] state_ff, state_in;
   logic [127:0] rk_ff, rk_in;
   logic [31:0]  rdata, wdata, prev_ff, prev_in, t, back;
   logic [7:0]   rc_ff, rc_in;
   logic [31:0]  hist_ff [8];
   logic [31:0]  seed;

   // Separate read for back word: keep last eight written words in a shift line.
   assign back = hist_ff[cmd.ks_back];

   always_comb begin
      seed = key[255 - 32*cmd.ks_seed_idx -: 32];
      t = prev_ff;
      if (cmd.ks_rot) t = aesd_pkg::sub_word({prev_ff[23:0], prev_ff[31:24]}) ^ {rc_ff, 24'h0};
      else if (cmd.ks_sub) t = aesd_pkg::sub_word(prev_ff);
      wdata = cmd.ks_seed ? seed : (back ^ t);
      prev_in = (cmd.ks_seed || cmd.ks_step) ? wdata : prev_ff;
      rc_in = cmd.rc_init ? 8'h01 : (cmd.ks_rot ? aesd_pkg::xt(rc_ff) : rc_ff);
   end

   aesd_ram #(.Width(32), .Depth(aesd_pkg::KeyWords)) u_rk (
      .clock (clock),
      .we    (cmd.ks_seed | cmd.ks_step),
      .waddr (cmd.ks_waddr),
      .wdata (wdata),
      .raddr (cmd.rk_raddr),
      .rdata (rdata)
   );

   always_comb begin
      rk_in = rk_ff;
      if (cmd.rk_col_we) rk_in[127 - 32*cmd.rk_col -: 32] = rdata;
   end

   function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
      logic [127:0] o;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            o[127 - 8*(r + 4*c) -: 8] =
               aesd_pkg::inv_sbox(s[127 - 8*(r + 4*((c + 4 - r) % 4)) -: 8]);
      return o;
   endfunction

   function automatic logic [127:0] inv_mix(input logic [127:0] s);
      logic [127:0] o;
      logic [7:0] a, a2, a4, a8;
      logic [7:0] m9 [4], m11 [4], m13 [4], m14 [4];
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            a = s[127 - 8*(r + 4*c) -: 8];
            a2 = aesd_pkg::xt(a); a4 = aesd_pkg::xt(a2); a8 = aesd_pkg::xt(a4);
            m9[r] = a8 ^ a; m11[r] = a8 ^ a2 ^ a; m13[r] = a8 ^ a4 ^ a;
            m14[r] = a8 ^ a4 ^ a2;
         end
         for (int r = 0; r < 4; r++)
            o[127 - 8*(r + 4*c) -: 8] = m14[r] ^ m11[(r+1)%4] ^ m13[(r+2)%4] ^ m9[(r+3)%4];
      end
      return o;
   endfunction

   always_comb begin
      state_in = state_ff;
      case (cmd.op)
         aesd_pkg::DP_LOAD:  state_in = {din_hi, din_lo} ^ rk_ff;
         aesd_pkg::DP_ROUND: state_in = inv_mix(inv_shift_sub(state_ff) ^ rk_ff);
         aesd_pkg::DP_LAST:  state_in = inv_shift_sub(state_ff) ^ rk_ff;
         default:            state_in = state_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      rk_ff    <= rk_in;
      prev_ff  <= prev_in;
      rc_ff    <= rc_in;
      if (cmd.ks_seed || cmd.ks_step) begin
         for (int i = 0; i < 7; i++) hist_ff[i] <= hist_ff[i+1];
         hist_ff[7] <= wdata;
      end
   end

   assign state_out = state_ff;
endmodule
`default_nettype wire

// File: src/aesd_ctrl.sv
`default_nettype none
module aesd_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [1:0]             key_size,
   input  wire logic                   sched_stale,
   input  wire logic                   start,
   input  wire logic                   out_free,
   output logic                        busy,
   output logic                        done,
   output logic                        sched_built,
   output aesd_pkg::aesd_cmd_type      cmd
);
   typedef enum logic [2:0] {S_IDLE, S_SEED, S_EXPAND, S_FETCH, S_APPLY, S_OUT} state_type;

   state_type state_ff;
   logic [5:0] widx_ff;
   logic [3:0] round_ff;
   logic [2:0] col_ff;
   logic [2:0] kcnt_ff;
   logic [3:0] nk, nr;
   logic [5:0] total;
   logic       first_ff;

   always_comb begin
      case (key_size)
         aesd_pkg::KEY_128: begin nk = 4'd4; nr = 4'd10; end
         aesd_pkg::KEY_192: begin nk = 4'd6; nr = 4'd12; end
         default:           begin nk = 4'd8; nr = 4'd14; end
      endcase
      total = 6'({nr, 2'b00} + 6'd4);
   end

   // Rounds numbered from nr down to 0; round nr is the initial key add.
   always_comb begin
      cmd = '0;
      cmd.op = aesd_pkg::DP_HOLD;
      cmd.ks_waddr = widx_ff;
      cmd.ks_seed_idx = widx_ff[2:0];
      cmd.ks_back = 3'(4'd8 - nk);
      cmd.rk_raddr = 6'({round_ff, 2'b00} + {4'd0, col_ff[1:0]});
      cmd.rk_col = 2'(col_ff - 3'd1);
      case (state_ff)
         S_SEED: begin
            cmd.ks_seed = 1'b1;
            cmd.rc_init = 1'b1;
         end
         S_EXPAND: begin
            cmd.ks_step = 1'b1;
            cmd.ks_rot = (kcnt_ff == 3'd0);
            cmd.ks_sub = (nk == 4'd8) && (kcnt_ff == 3'd4);
         end
         S_FETCH: cmd.rk_col_we = (col_ff != 3'd0);
         S_APPLY: begin
            if (first_ff) cmd.op = aesd_pkg::DP_LOAD;
            else if (round_ff == 4'd0) cmd.op = aesd_pkg::DP_LAST;
            else cmd.op = aesd_pkg::DP_ROUND;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         widx_ff <= '0; round_ff <= '0; col_ff <= '0; kcnt_ff <= '0;
         first_ff <= 1'b0;
         sched_built <= 1'b0;
      end else begin
         sched_built <= 1'b0;
         case (state_ff)
            S_IDLE: if (start) begin
               widx_ff <= '0;
               round_ff <= nr;
               col_ff <= '0;
               first_ff <= 1'b1;
               state_ff <= sched_stale ? S_SEED : S_FETCH;
            end
            S_SEED: begin
               widx_ff <= widx_ff + 6'd1;
               if (widx_ff == 6'(nk - 4'd1)) begin
                  kcnt_ff <= '0;
                  state_ff <= S_EXPAND;
               end
            end
            S_EXPAND: begin
               widx_ff <= widx_ff + 6'd1;
               kcnt_ff <= (kcnt_ff == 3'(nk - 4'd1)) ? 3'd0 : kcnt_ff + 3'd1;
               if (widx_ff == total - 6'd1) begin
                  sched_built <= 1'b1;
                  state_ff <= S_FETCH;
               end
            end
            S_FETCH: begin
               col_ff <= col_ff + 3'd1;
               if (col_ff == 3'd4) state_ff <= S_APPLY;
            end
            S_APPLY: begin
               col_ff <= '0;
               first_ff <= 1'b0;
               if (round_ff == 4'd0 && !first_ff) state_ff <= S_OUT;
               else begin
                  if (!first_ff || round_ff != nr) round_ff <= round_ff - 4'd1;
                  else round_ff <= round_ff - 4'd1;
                  state_ff <= S_FETCH;
               end
            end
            S_OUT: if (out_free) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign done = (state_ff == S_OUT) && out_free;
endmodule
`default_nettype wire

// File: src/aes_block_decrypt_top.sv
`default_nettype none
// Channel   Direction  Handshake          Word
// req_      in         req_valid/stall    cipher_hi, cipher_lo
// rsp_      out        rsp_valid/stall    plain_hi, plain_lo
// csr_      in         csr_write_en       index 0..4, 64-bit data
//
// A block runs nr+1 rounds. Each round steps through key RAM reads for the four round-key
// columns, the first step only filling the read register, then one apply step; the result
// is then handed off through the output state.
// After a key write the first block also expands the schedule into 4*(nr+1) key words.
// Reset is synchronous and clears control and the key registers.
// The result sits in an output register; the next word is taken while it waits,
// and its result is held back until the register empties.
module aes_block_decrypt_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [63:0] req_cipher_hi,
   input  wire logic [63:0] req_cipher_lo,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_plain_hi,
   output logic [63:0]      rsp_plain_lo,
   input  wire logic        csr_write_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data
);
   logic [1:0]   key_size_ff;
   logic [255:0] key_ff;
   logic         stale_ff;
   logic [127:0] din_ff, state;
   logic         busy, done, built, start;
   logic         rsp_valid_ff;
   logic [127:0] rsp_ff;
   aesd_pkg::aesd_cmd_type cmd;

   assign start = req_valid && !busy;
   assign req_stall = busy;

   // Hold the config; any valid write marks the schedule stale.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_size_ff <= '0;
         key_ff <= '0;
         stale_ff <= 1'b1;
      end else begin
         if (built) stale_ff <= 1'b0;
         if (csr_write_en) begin
            case (csr_index)
               aesd_pkg::CSR_KEY_SIZE: begin key_size_ff <= csr_data[1:0]; stale_ff <= 1'b1; end
               aesd_pkg::CSR_KEY_W0: begin key_ff[255:192] <= csr_data; stale_ff <= 1'b1; end
               aesd_pkg::CSR_KEY_W1: begin key_ff[191:128] <= csr_data; stale_ff <= 1'b1; end
               aesd_pkg::CSR_KEY_W2: begin key_ff[127:64]  <= csr_data; stale_ff <= 1'b1; end
               aesd_pkg::CSR_KEY_W3: begin key_ff[63:0]    <= csr_data; stale_ff <= 1'b1; end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock)
      if (start) din_ff <= {req_cipher_hi, req_cipher_lo};

   aesd_ctrl u_ctrl (
      .clock(clock), .reset(reset), .key_size(key_size_ff), .sched_stale(stale_ff),
      .start(start), .out_free(!rsp_valid_ff || !rsp_stall), .busy(busy), .done(done),
      .sched_built(built), .cmd(cmd)
   );

   aesd_datapath u_dp (
      .clock(clock), .cmd(cmd), .key(key_ff), .din_hi(din_ff[127:64]),
      .din_lo(din_ff[63:0]), .state_out(state)
   );

   // Output register: load on done, drop when taken.
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (done) rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
   end
   always_ff @(posedge clock)
      if (done) rsp_ff <= state;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_plain_hi = rsp_ff[127:64];
   assign rsp_plain_lo = rsp_ff[63:0];
endmodule
`default_nettype wire

// File: src/aesd_checker.sv
`default_nettype none
module aesd_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic [63:0] rsp_plain_hi
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_plain_hi)) else $error("rsp held");
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall) else $error("accept not busy");
   a_no_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("rsp after reset");
endmodule

bind aes_block_decrypt_top aesd_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_plain_hi(rsp_plain_hi)
);
`default_nettype wire
